// ----- rtl/vfvi_pkg.sv -----
// Shared widths, types and codes of the venturi flow volume integrator.
`default_nettype none

package vfvi_pkg;

    // Fixed-point format of the square root and the flow
    localparam int FRACTION_BITS = 8;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int P_W     = 14;
    localparam int TIME_W  = 32;
    localparam int SCALE_W = 16;
    localparam int FLOW_W  = 20;
    localparam int DZ_W    = 16;
    localparam int VOL_W   = 48;
    localparam int SUM_W   = 64;

    // Square root: radicand is the pressure shifted up by two fraction fields
    localparam int RAD_W     = P_W + 2 * FRACTION_BITS;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int SQ_CNT_W  = $clog2(ROOT_W);

    // Flow datapath
    localparam int PROD_W = ROOT_W + SCALE_W;
    localparam int BASE_W = PROD_W - FRACTION_BITS;
    localparam int RAW_W  = BASE_W + 2;
    localparam int INC_W  = TIME_W + 1 + FLOW_W + 1;

    // Volume divide: 120 = 8 * 15, shift by 3 then one hex digit a step by 15
    localparam int DIV_SHIFT  = 3;
    localparam int DIGIT_W    = 4;
    localparam int DIGITS     = SUM_W / DIGIT_W;
    localparam int DIG_CNT_W  = $clog2(DIGITS);

    // Stream widths
    localparam int IN_W  = 2 * BYTE_W + TIME_W;
    localparam int OUT_W = 2 * FLOW_W + VOL_W;

    // Queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOW_SCALE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE   = 2'd2;
    localparam logic [SCALE_W-1:0]   FLOW_SCALE_RESET = 16'd2204;

    typedef struct packed {
        logic [SCALE_W-1:0] flow_scale;
        logic [FLOW_W-1:0]  zero_offset;
        logic [DZ_W-1:0]    dead_zone;
    } cfg_t;

    // One sample waiting for the back end
    typedef struct packed {
        logic [TIME_W-1:0] dt;
        logic [P_W-1:0]    pressure;
    } q_item_t;

    typedef struct packed {
        logic full;
        logic valid;
    } q_status_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_SQRT,
        BK_MUL,
        BK_FLOW,
        BK_DZ,
        BK_INC,
        BK_ACC,
        BK_ABS,
        BK_DIV,
        BK_OUT
    } back_state_t;

endpackage

`default_nettype wire

// ----- rtl/vfvi_front.sv -----
// Front end: accepts samples, masks the pressure and forms the elapsed time.
`default_nettype none

module vfvi_front
    import vfvi_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [IN_W-1:0]  s_tdata,
    input  wire q_status_t        q_status,
    output logic                  push,
    output q_item_t               push_item
);

    logic [TIME_W-1:0] last_time_reg;
    logic [TIME_W-1:0] last_time_next;
    logic              started_reg;
    logic              started_next;
    logic [TIME_W-1:0] now;

    assign now      = s_tdata[IN_W-1:2*BYTE_W];
    assign s_tready = !q_status.full;
    assign push     = s_tvalid && s_tready;

    // Classify the sample: the first one after reset has no elapsed time
    always_comb
    begin
        push_item.pressure = {s_tdata[P_W-BYTE_W-1:0], s_tdata[2*BYTE_W-1:BYTE_W]};
        push_item.dt       = started_reg ? (now - last_time_reg) : '0;
        last_time_next     = last_time_reg;
        started_next       = started_reg;
        if (push)
        begin
            last_time_next = now;
            started_next   = 1'b1;
        end
    end

    // Hold the timestamp of the last accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg <= '0;
            started_reg   <= 1'b0;
        end
        else
        begin
            last_time_reg <= last_time_next;
            started_reg   <= started_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/vfvi_queue.sv -----
// Short queue that decouples the front end from the back end.
`default_nettype none

module vfvi_queue
    import vfvi_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire q_item_t push_item,
    input  wire logic    pop,
    output q_item_t      head_item,
    output q_status_t    q_status
);

    q_item_t              entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;
    logic                 do_push;
    logic                 do_pop;

    assign q_status.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign q_status.valid = (count_reg != '0);
    assign head_item      = entry_reg[rd_ptr_reg];
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && q_status.valid;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/vfvi_sqrt.sv -----
// Bit-serial integer square root, one root bit per cycle.
`default_nettype none

module vfvi_sqrt
    import vfvi_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [RAD_W-1:0]  radicand,
    output logic                   done,
    output logic [ROOT_W-1:0]      root
);

    logic [RAD_W-1:0]    rad_reg;
    logic [ROOT_W:0]     rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [SQ_CNT_W-1:0] cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [ROOT_W+2:0]   cand;
    logic [ROOT_W+2:0]   trial;
    logic [ROOT_W+2:0]   diff;
    logic                take;

    assign done = done_reg;
    assign root = root_reg;

    // Try to subtract 4*root+1 from the remainder with the next two bits
    assign cand  = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign diff  = cand - trial;
    assign take  = (cand >= trial);

    // Control: run ROOT_W steps, then flag done for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == SQ_CNT_W'(ROOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift in two radicand bits and one root bit per step
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= rad_reg << 2;
            if (take)
            begin
                rem_reg  <= diff[ROOT_W:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= cand[ROOT_W:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/vfvi_back.sv -----
// Back end: flow from the root, trapezoid integration and volume divide.
`default_nettype none

module vfvi_back
    import vfvi_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_t              cfg,
    input  wire q_status_t         q_status,
    input  wire q_item_t           head_item,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [FLOW_W-1:0]      out_raw_flow,
    output logic [FLOW_W-1:0]      out_flow,
    output logic [VOL_W-1:0]       out_volume
);

    localparam logic signed [RAW_W-1:0] RAW_MAX = RAW_W'((2 ** (FLOW_W - 1)) - 1);
    localparam logic signed [RAW_W-1:0] RAW_MIN = -RAW_W'(2 ** (FLOW_W - 1));
    localparam logic [SUM_W-1:0] VOL_LIMIT = SUM_W'(1) << (VOL_W - 1);
    localparam logic [VOL_W-1:0] VOL_MAX   = {1'b0, {(VOL_W-1){1'b1}}};
    localparam logic [VOL_W-1:0] VOL_MIN   = {1'b1, {(VOL_W-1){1'b0}}};
    localparam logic [SUM_W-1:0] SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};

    // One quotient digit of x / 15 for x below 240
    function automatic logic [DIGIT_W-1:0] div15_digit(input logic [2*DIGIT_W-1:0] x);
        logic [12:0] t;
        t = (13'(x) + 13'd1) * 13'd17;
        return t[11:8];
    endfunction

    back_state_t         state_reg;
    back_state_t         state_next;
    logic                sqrt_start;
    logic                sqrt_done;
    logic [ROOT_W-1:0]   root;
    logic                out_free;
    logic                out_load;

    logic [TIME_W-1:0]   dt_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [FLOW_W-1:0]   raw_reg;
    logic [FLOW_W-1:0]   cur_reg;
    logic [INC_W-1:0]    inc_reg;
    logic [FLOW_W-1:0]   prev_flow_reg;
    logic [SUM_W-1:0]    volume_sum_reg;
    logic                neg_reg;
    logic [SUM_W-1:0]    dvd_reg;
    logic [DIGIT_W-1:0]  rem_reg;
    logic [SUM_W-1:0]    quot_reg;
    logic [DIG_CNT_W-1:0] dig_cnt_reg;

    logic                out_valid_reg;
    logic [FLOW_W-1:0]   out_raw_reg;
    logic [FLOW_W-1:0]   out_flow_reg;
    logic [VOL_W-1:0]    out_vol_reg;

    logic [BASE_W-1:0]       base;
    logic signed [RAW_W-1:0] raw_wide;
    logic [FLOW_W-1:0]       raw_sat;
    logic signed [FLOW_W:0]  raw_ext;
    logic [FLOW_W:0]         raw_mag;
    logic signed [FLOW_W:0]  flow_pair;
    logic signed [INC_W-1:0] inc_prod;
    logic [SUM_W:0]          sum_ext;
    logic [SUM_W-1:0]        sum_sat;
    logic [SUM_W-1:0]        sum_mag;
    logic [2*DIGIT_W-1:0]    dig_x;
    logic [DIGIT_W-1:0]      dig_q;
    logic [2*DIGIT_W-1:0]    dig_rem;
    logic [VOL_W-1:0]        vol;

    vfvi_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand ({head_item.pressure, {(2*FRACTION_BITS){1'b0}}}),
        .done     (sqrt_done),
        .root     (root)
    );

    assign out_free     = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign out_raw_flow = out_raw_reg;
    assign out_flow     = out_flow_reg;
    assign out_volume   = out_vol_reg;

    // Sequence one item through the datapath
    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        sqrt_start = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_status.valid)
                begin
                    pop        = 1'b1;
                    sqrt_start = 1'b1;
                    state_next = BK_SQRT;
                end
            end
            BK_SQRT:
            begin
                if (sqrt_done)
                begin
                    state_next = BK_MUL;
                end
            end
            BK_MUL:  state_next = BK_FLOW;
            BK_FLOW: state_next = BK_DZ;
            BK_DZ:   state_next = BK_INC;
            BK_INC:  state_next = BK_ACC;
            BK_ACC:  state_next = BK_ABS;
            BK_ABS:  state_next = BK_DIV;
            BK_DIV:
            begin
                if (dig_cnt_reg == DIG_CNT_W'(DIGITS - 1))
                begin
                    state_next = BK_OUT;
                end
            end
            BK_OUT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Offset-corrected flow, saturated to the flow range
    always_comb
    begin
        base     = prod_reg[PROD_W-1:FRACTION_BITS];
        raw_wide = $signed({2'b00, base})
                 - $signed({{(RAW_W-FLOW_W){cfg.zero_offset[FLOW_W-1]}}, cfg.zero_offset});
        priority if (raw_wide > RAW_MAX)
        begin
            raw_sat = RAW_MAX[FLOW_W-1:0];
        end
        else if (raw_wide < RAW_MIN)
        begin
            raw_sat = RAW_MIN[FLOW_W-1:0];
        end
        else
        begin
            raw_sat = raw_wide[FLOW_W-1:0];
        end
    end

    // Magnitude for the dead zone, trapezoid increment, saturating sum
    always_comb
    begin
        raw_ext   = $signed({raw_reg[FLOW_W-1], raw_reg});
        raw_mag   = (raw_ext < 0) ? $unsigned(-raw_ext) : $unsigned(raw_ext);
        flow_pair = $signed({prev_flow_reg[FLOW_W-1], prev_flow_reg})
                  + $signed({cur_reg[FLOW_W-1], cur_reg});
        inc_prod  = $signed({1'b0, dt_reg}) * flow_pair;
        sum_ext   = {volume_sum_reg[SUM_W-1], volume_sum_reg}
                  + {{(SUM_W+1-INC_W){inc_reg[INC_W-1]}}, inc_reg};
        if (sum_ext[SUM_W] != sum_ext[SUM_W-1])
        begin
            sum_sat = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sum_sat = sum_ext[SUM_W-1:0];
        end
        sum_mag = volume_sum_reg[SUM_W-1] ? (~volume_sum_reg + 1'b1) : volume_sum_reg;
    end

    // One hex digit of the divide by 15, then sign and saturate the volume
    always_comb
    begin
        dig_x   = {rem_reg, dvd_reg[SUM_W-1 -: DIGIT_W]};
        dig_q   = div15_digit(dig_x);
        dig_rem = dig_x - (2*DIGIT_W)'(dig_q) * (2*DIGIT_W)'(15);
        if (neg_reg)
        begin
            vol = (quot_reg >= VOL_LIMIT) ? VOL_MIN : (~quot_reg[VOL_W-1:0] + 1'b1);
        end
        else
        begin
            vol = (quot_reg >= VOL_LIMIT) ? VOL_MAX : quot_reg[VOL_W-1:0];
        end
    end

    // Integration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_flow_reg  <= '0;
            volume_sum_reg <= '0;
        end
        else if (state_reg == BK_ACC)
        begin
            prev_flow_reg  <= cur_reg;
            volume_sum_reg <= sum_sat;
        end
    end

    // Datapath stages, each loaded in its own state
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            BK_IDLE:
            begin
                if (pop)
                begin
                    dt_reg <= head_item.dt;
                end
            end
            BK_MUL:
            begin
                prod_reg <= PROD_W'(root) * PROD_W'(cfg.flow_scale);
            end
            BK_FLOW:
            begin
                raw_reg <= raw_sat;
            end
            BK_DZ:
            begin
                cur_reg <= (raw_mag < (FLOW_W+1)'(cfg.dead_zone)) ? '0 : raw_reg;
            end
            BK_INC:
            begin
                inc_reg <= inc_prod;
            end
            BK_ABS:
            begin
                neg_reg     <= volume_sum_reg[SUM_W-1];
                dvd_reg     <= sum_mag >> DIV_SHIFT;
                rem_reg     <= '0;
                quot_reg    <= '0;
                dig_cnt_reg <= '0;
            end
            BK_DIV:
            begin
                dvd_reg     <= dvd_reg << DIGIT_W;
                rem_reg     <= dig_rem[DIGIT_W-1:0];
                quot_reg    <= {quot_reg[SUM_W-DIGIT_W-1:0], dig_q};
                dig_cnt_reg <= dig_cnt_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Output register: hold a result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_raw_reg  <= raw_reg;
            out_flow_reg <= cur_reg;
            out_vol_reg  <= vol;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/venturi_flow_volume_integrator_core.sv -----
// Top level of the venturi flow volume integrator with its configuration registers.
`default_nettype none

// Each input item carries two pressure bytes and a millisecond timestamp; each
// yields one result: offset-corrected flow, flow after the dead zone (both
// signed Q8 L/min) and the trapezoid-integrated volume (sum of dt*(prev+cur)
// divided by 120, truncated toward zero, saturated to 48 bits signed). The first
// item after reset integrates with dt = 0. A two-entry queue sits between the
// input and the compute sequencer, and a result register at the output, so input
// and output stall independently. The sequencer takes one item at a time, in order
// through queue pop, the bit-serial square root, scale multiply, offset, dead
// zone, increment multiply, accumulate, magnitude, the hex-digit divide by 15 and
// result load, which waits while the output register is full. Configuration writes
// take effect on the next clock edge and should be made only while no item is in
// flight.

module venturi_flow_volume_integrator_core
    import vfvi_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [7:0] pressure_high_byte, [15:8] pressure_low_byte, [47:16] time_ms
    input  wire logic [IN_W-1:0]       s_tdata,
    // Output stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [19:0] raw_flow, [39:20] flow, [87:40] volume
    output logic [OUT_W-1:0]           m_tdata,
    // Configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t              cfg_reg;
    cfg_t              cfg_next;
    q_status_t         q_status;
    q_item_t           push_item;
    q_item_t           head_item;
    logic              push;
    logic              pop;
    logic [FLOW_W-1:0] out_raw_flow;
    logic [FLOW_W-1:0] out_flow;
    logic [VOL_W-1:0]  out_volume;

    // Decode configuration writes; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FLOW_SCALE:  cfg_next.flow_scale  = cfg_data[SCALE_W-1:0];
                CFG_ZERO_OFFSET: cfg_next.zero_offset = cfg_data[FLOW_W-1:0];
                CFG_DEAD_ZONE:   cfg_next.dead_zone   = cfg_data[DZ_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flow_scale  <= FLOW_SCALE_RESET;
            cfg_reg.zero_offset <= '0;
            cfg_reg.dead_zone   <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    vfvi_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    vfvi_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_status  (q_status)
    );

    vfvi_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_status     (q_status),
        .head_item    (head_item),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_raw_flow (out_raw_flow),
        .out_flow     (out_flow),
        .out_volume   (out_volume)
    );

    // Pack the result fields, first field lowest
    assign m_tdata = {out_volume, out_flow, out_raw_flow};

endmodule

`default_nettype wire

// ----- tb/venturi_flow_volume_integrator_core_tb.sv -----
// Testbench for the venturi flow volume integrator: directed rows, random items, self-check.
`default_nettype none

module venturi_flow_volume_integrator_core_tb;
    import vfvi_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 5;
    localparam int MAX_IDLE       = 13;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 9;
    localparam int PHASE_ITEMS    = 92;
    localparam int FRAC           = 8;
    localparam int ROOT_BITS      = 15;

    // Index past the register list; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint SUM_MIN = -SUM_MAX - 1;
    localparam longint VOL_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint VOL_MIN = -VOL_MAX - 1;
    localparam longint FLOW_MAX = 524287;
    localparam longint FLOW_MIN = -524288;

    // Same layout as m_tdata: raw_flow lowest, volume highest
    typedef struct packed {
        logic [VOL_W-1:0]  volume;
        logic [FLOW_W-1:0] flow;
        logic [FLOW_W-1:0] raw;
    } flow_result_t;

    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
        logic [BYTE_W-1:0]     hi;
        logic [BYTE_W-1:0]     lo;
        logic [TIME_W-1:0]     stamp;
        logic                  has_known;
        flow_result_t          known;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // [7:0] pressure_high_byte, [15:8] pressure_low_byte, [47:16] time_ms
    logic [IN_W-1:0]       s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // [19:0] raw_flow, [39:20] flow, [87:40] volume
    logic [OUT_W-1:0]      m_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predictor copy of the registers and the integrator state
    logic [SCALE_W-1:0]       cf_scale  = FLOW_SCALE_RESET;
    logic signed [FLOW_W-1:0] cf_offset = '0;
    logic [DZ_W-1:0]          cf_dz     = '0;
    logic [TIME_W-1:0]        st_last_time = '0;
    longint                   st_prev_flow = 0;
    longint                   st_sum       = 0;
    bit                       st_started   = 1'b0;

    flow_result_t flow_expect_q[$];
    stim_row_t    stim_rows[$];
    int unsigned  mismatches = 0;
    bit           quiet_tx = 1'b0;
    bit           quiet_rx = 1'b0;
    bit           hold_request = 1'b0;
    logic [TIME_W-1:0] clock_ms = '0;

    venturi_flow_volume_integrator_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Compute the flow and volume that one sample yields, and advance the integrator
    task automatic predict_flow(input logic [BYTE_W-1:0] hi, input logic [BYTE_W-1:0] lo,
                                input logic [TIME_W-1:0] stamp, output flow_result_t res);
        logic [P_W-1:0]        pressure;
        logic [2*ROOT_BITS-1:0] radicand;
        logic [ROOT_BITS-1:0]  root;
        logic [ROOT_BITS-1:0]  trial;
        logic [TIME_W-1:0]     dt;
        longint                base;
        longint                raw;
        longint                mag;
        longint                cur;
        longint                inc;
        longint                total;
        longint                vol;
        pressure = {hi[5:0], lo};
        radicand = {pressure, {(2 * FRAC){1'b0}}};
        root = '0;
        // Build the root one bit at a time from the top
        for (int b = ROOT_BITS - 1; b >= 0; b--)
        begin
            trial = root | (ROOT_BITS'(1) << b);
            if (longint'(trial) * longint'(trial) <= longint'(radicand))
                root = trial;
        end
        base = (longint'(root) * longint'(cf_scale)) >>> FRAC;
        raw = base - longint'(cf_offset);
        if (raw > FLOW_MAX)
            raw = FLOW_MAX;
        if (raw < FLOW_MIN)
            raw = FLOW_MIN;
        mag = (raw < 0) ? -raw : raw;
        cur = (mag < longint'(cf_dz)) ? 0 : raw;
        dt = st_started ? stamp - st_last_time : '0;
        inc = longint'(dt) * (st_prev_flow + cur);
        // Saturate the running sum instead of letting it wrap
        total = st_sum + inc;
        if (inc > 0 && total < st_sum)
            total = SUM_MAX;
        else if (inc < 0 && total > st_sum)
            total = SUM_MIN;
        st_sum = total;
        st_last_time = stamp;
        st_prev_flow = cur;
        st_started = 1'b1;
        vol = total / 120;
        if (vol > VOL_MAX)
            vol = VOL_MAX;
        if (vol < VOL_MIN)
            vol = VOL_MIN;
        res.raw = raw[FLOW_W-1:0];
        res.flow = cur[FLOW_W-1:0];
        res.volume = vol[VOL_W-1:0];
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
    endtask

    function automatic void add_item(input logic [7:0] hi, input logic [7:0] lo,
                                     input logic [31:0] stamp);
        stim_row_t row;
        row = '0;
        row.hi = hi;
        row.lo = lo;
        row.stamp = stamp;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_known(input logic [7:0] hi, input logic [7:0] lo,
                                      input logic [31:0] stamp, input flow_result_t known);
        stim_row_t row;
        row = '0;
        row.hi = hi;
        row.lo = lo;
        row.stamp = stamp;
        row.has_known = 1'b1;
        row.known = known;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] index,
                                    input logic [CFG_DATA_W-1:0] value);
        stim_row_t row;
        row = '0;
        row.is_cfg = 1'b1;
        row.index = index;
        row.value = value;
        stim_rows.push_back(row);
    endfunction

    // Offer one item after a random gap and queue its expected result once accepted
    task automatic send_item(input logic [7:0] hi, input logic [7:0] lo,
                             input logic [31:0] stamp, input bit has_known,
                             input flow_result_t known);
        int unsigned  gap;
        flow_result_t pred;
        gap = quiet_tx ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {stamp, lo, hi};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_flow(hi, lo, stamp, pred);
        flow_expect_q.push_back(has_known ? known : pred);
    endtask

    task automatic send_random_item();
        if ($urandom_range(0, 19) == 0)
            clock_ms = $urandom;
        else
            clock_ms = clock_ms + $urandom_range(0, 2000);
        send_item(8'($urandom), 8'($urandom), clock_ms, 1'b0, '0);
    endtask

    // Stop offering and wait until every expected result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (flow_expect_q.size() != 0)
            @(posedge clk);
    endtask

    // Write one register and mirror it in the predictor; caller lowers cfg_we
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        case (index)
            CFG_FLOW_SCALE:  cf_scale = value[SCALE_W-1:0];
            CFG_ZERO_OFFSET: cf_offset = value;
            CFG_DEAD_ZONE:   cf_dz = value[DZ_W-1:0];
            default: ;
        endcase
    endtask

    // Result receiver: random stalls, one long hold-off on request, check each item
    initial
    begin : receiver
        int unsigned  stall;
        flow_result_t got;
        flow_result_t want;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = quiet_rx ? 0 : $urandom_range(0, MAX_IDLE);
            if (hold_request)
            begin
                stall = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            got = m_tdata;
            if (flow_expect_q.size() == 0)
            begin
                report_mismatch("unexpected result", 64'(got.raw), '0);
            end
            else
            begin
                want = flow_expect_q.pop_front();
                if (got.raw !== want.raw)
                    report_mismatch("raw_flow", 64'(got.raw), 64'(want.raw));
                if (got.flow !== want.flow)
                    report_mismatch("flow", 64'(got.flow), 64'(want.flow));
                if (got.volume !== want.volume)
                    report_mismatch("volume", 64'(got.volume), 64'(want.volume));
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial
    begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Main stimulus
    initial
    begin : stimulus
        stim_row_t          row;
        bit                 cfg_open;
        logic [31:0]        stamp;
        logic [SCALE_W-1:0] scale_val;
        logic [FLOW_W-1:0]  offset_val;
        logic [DZ_W-1:0]    dz_val;

        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_FLOW_SCALE;
        cfg_data <= '0;

        // Reset settings: zero pressure, ignored upper bits, unit pressure, full scale
        add_known(8'h00, 8'h00, 32'd0, '{volume: '0, flow: '0, raw: '0});
        add_known(8'hC0, 8'h00, 32'd1000, '{volume: '0, flow: '0, raw: '0});
        add_known(8'h00, 8'h01, 32'd1120, '{volume: 48'd2204, flow: 20'd2204, raw: 20'd2204});
        add_item(8'h3F, 8'hFF, 32'd1120);
        add_item(8'hFF, 8'hFF, 32'h0000_0100);
        add_item(8'h80, 8'h80, 32'hFFFF_FFFF);
        add_item(8'h3F, 8'hFF, 32'h8000_0000);

        // Maximum scale, negative offset: clip raw flow, drive volume to its upper limit
        add_cfg(CFG_SPARE, 20'hFFFFF);
        add_cfg(CFG_FLOW_SCALE, 20'hFFFFF);
        add_cfg(CFG_ZERO_OFFSET, 20'(-300000));
        add_cfg(CFG_DEAD_ZONE, 20'd0);
        stamp = 32'h7FFF_FFF0;
        for (int i = 0; i < 4; i++)
        begin
            add_item(8'h3F, 8'hFF, stamp);
            stamp -= 32'd16;
        end

        // Zero scale, largest offset: deep negative flow drives the volume far negative
        add_cfg(CFG_FLOW_SCALE, 20'd0);
        add_cfg(CFG_ZERO_OFFSET, 20'h7FFFF);
        add_cfg(CFG_DEAD_ZONE, 20'hFFFFF);
        for (int i = 0; i < 9; i++)
        begin
            add_item(8'h2A, 8'h55, stamp);
            stamp -= 32'd16;
        end

        // Dead zone edges: magnitude equal to the threshold passes, just below is zeroed
        add_cfg(CFG_ZERO_OFFSET, 20'(-1000));
        add_cfg(CFG_DEAD_ZONE, 20'd1000);
        add_item(8'h01, 8'h00, stamp + 32'd5);
        add_cfg(CFG_DEAD_ZONE, 20'd1001);
        add_item(8'h01, 8'h00, stamp + 32'd10);
        add_cfg(CFG_ZERO_OFFSET, 20'd1000);
        add_item(8'h01, 8'h00, stamp + 32'd20);
        clock_ms = stamp + 32'd20;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed rows; group register writes while idle
        cfg_open = 1'b0;
        foreach (stim_rows[i])
        begin
            row = stim_rows[i];
            if (row.is_cfg)
            begin
                if (!cfg_open)
                    drain_results();
                write_register(row.index, row.value);
                cfg_open = 1'b1;
            end
            else
            begin
                if (cfg_open)
                begin
                    cfg_we <= 1'b0;
                    cfg_open = 1'b0;
                end
                send_item(row.hi, row.lo, row.stamp, row.has_known, row.known);
            end
        end

        // Random phases, each with fresh settings and its own idling mix
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(0, 3))
                0: scale_val = '0;
                1: scale_val = '1;
                2: scale_val = FLOW_SCALE_RESET;
                default: scale_val = SCALE_W'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0: offset_val = 20'(-300000);
                1: offset_val = 20'd300000;
                2: offset_val = FLOW_W'($urandom);
                3: offset_val = '0;
                default: offset_val = FLOW_W'($urandom_range(0, 600000)) - 20'd300000;
            endcase
            case ($urandom_range(0, 3))
                0: dz_val = '0;
                1: dz_val = '1;
                default: dz_val = DZ_W'($urandom_range(0, 5000));
            endcase
            drain_results();
            write_register(CFG_FLOW_SCALE, {4'($urandom), scale_val});
            write_register(CFG_ZERO_OFFSET, offset_val);
            write_register(CFG_DEAD_ZONE, {4'($urandom), dz_val});
            if ($urandom_range(0, 2) == 0)
                write_register(CFG_SPARE, CFG_DATA_W'($urandom));
            cfg_we <= 1'b0;

            quiet_tx = (phase == 1) || ($urandom_range(0, 3) == 0);
            quiet_rx = (phase == 1) || ($urandom_range(0, 3) == 0);
            if (phase == 2 || phase == 6)
                hold_request = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random_item();
        end

        // Let everything settle, then give the verdict
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/vfvi_pkg.sv
rtl/vfvi_front.sv
rtl/vfvi_queue.sv
rtl/vfvi_sqrt.sv
rtl/vfvi_back.sv
rtl/venturi_flow_volume_integrator_core.sv
tb/venturi_flow_volume_integrator_core_tb.sv
